>>> src/life_pkg.sv
// ----------------------------------------------------------------------------
// life_pkg: shared constants and types of the life grid block
// Grid limits, field widths, command and state codes, and the 3x3 neighbor
// window that travels from the sequencer to the rule unit.
// ----------------------------------------------------------------------------
`default_nettype none

package life_pkg;

  // Largest grid the cell store holds.
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;

  // Cell coordinates and the counters that may also hold the limits.
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 2);

  // Configuration port.
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     GRID_DIM_RESET  = CFG_W'(100);

  // Width used to compare sizes, counters and coordinates.
  localparam int DIM_W0 = (CFG_W > CCNT_W) ? CFG_W : CCNT_W;
  localparam int DIM_W  = (DIM_W0 > RCNT_W) ? DIM_W0 : RCNT_W;

  // B3/S23 rule.
  localparam int NBR_W        = 4;
  localparam int BIRTH_COUNT  = 3;
  localparam int SURVIVE_LOW  = 2;
  localparam int SURVIVE_HIGH = 3;

  localparam int CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FETCH,
    ST_LOAD,
    ST_SWEEP,
    ST_WRITE,
    ST_RESP
  } state_t;

  // Three columns of three cells. Bit 0 is the row above, bit 1 the row of
  // the cell itself, bit 2 the row below.
  typedef struct packed {
    logic [2:0] left;
    logic [2:0] mid;
    logic [2:0] right;
  } win_t;

endpackage

`default_nettype wire

>>> src/life_ram.sv
// ----------------------------------------------------------------------------
// life_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module life_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/life_rule_unit.sv
// ----------------------------------------------------------------------------
// life_rule_unit: neighbor count and B3/S23 decision for one cell
// Counts the eight neighbors in a 3x3 window and gives the next state of the
// center cell.
// ----------------------------------------------------------------------------
`default_nettype none

module life_rule_unit (
  input  life_pkg::win_t win,
  output logic           next_alive
);
  import life_pkg::*;

  logic [NBR_W-1:0] count;
  logic             alive;

  always_comb begin
    count = '0;
    for (int i = 0; i < 3; i++) begin
      count = count + NBR_W'(win.left[i]) + NBR_W'(win.right[i]);
    end
    count = count + NBR_W'(win.mid[0]) + NBR_W'(win.mid[2]);
  end

  assign alive = win.mid[1];

  assign next_alive = (count == NBR_W'(BIRTH_COUNT)) ||
                      (alive && (count >= NBR_W'(SURVIVE_LOW)) &&
                       (count <= NBR_W'(SURVIVE_HIGH)));

endmodule

`default_nettype wire

>>> src/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step: one-bit life grid with host access and stepping
// Holds a grid of cells in a row-wide memory. The host writes and reads single
// cells and asks for one B3/S23 generation step over the grid in use.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                  Direction  Word
// config    cfg_we, cfg_index, cfg_data              in         register write
// input     in_valid, in_stall, command/col/row/...  in         one command
// output    out_valid, out_stall, cell_state         out        one result bit
//
// A cell read or write inside the grid passes through accept, memory
// access and result; an access outside the grid, the unused command and
// a step on an empty grid go from accept straight to result.
// A step fetches the first two rows, then for each row in use loads the
// next, sweeps one cell per cycle through the shared neighbor/rule unit
// and writes the new row back. After reset the block clears the store
// one row per cycle and holds in_stall high meanwhile; configuration
// writes are taken always. A waiting result sits in the output register,
// so the next word can be accepted while out_stall is high; a command
// finishes only once the output register is free.
//
`default_nettype none

module life_grid_generation_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [life_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [life_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [life_pkg::CMD_W-1:0]     command,
  input  logic [life_pkg::COL_W-1:0]     col,
  input  logic [life_pkg::ROW_W-1:0]     row,
  input  logic                           cell_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           cell_state
);
  import life_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [DIM_W-1:0] cols_use, rows_use;

  // Old generation of the rows above, at and below the row being swept, and
  // the new row that collects the results.
  logic [MAX_COLS-1:0] prev_row, cur_row, next_row, new_row;
  logic [2:0]          win_left, win_mid, col_raw;
  win_t                win;
  logic                rule_bit, new_bit;

  logic [CCNT_W-1:0] col_cnt;
  logic [ROW_W-1:0]  proc_row;
  logic [RCNT_W-1:0] fetch_row;

  cmd_t             cmd_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             value_q;
  logic             result_bit;

  logic in_accept, out_take, resp_load;
  logic addr_in_grid, grid_empty, col_live, cell_live, fetch_live, last_row, clear_done;

  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  // Size in use is the configured size clamped to what the store holds.
  assign cols_use = (DIM_W'(grid_width) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                             : DIM_W'(grid_width);
  assign rows_use = (DIM_W'(grid_height) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                              : DIM_W'(grid_height);

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign resp_load  = (state == ST_RESP) && (!out_valid || !out_stall);

  assign addr_in_grid = (DIM_W'(col) < cols_use) && (DIM_W'(row) < rows_use);
  assign grid_empty   = (cols_use == '0) || (rows_use == '0);
  assign fetch_live   = DIM_W'(fetch_row) < rows_use;
  assign last_row     = (DIM_W'(proc_row) + DIM_W'(1)) == rows_use;
  assign clear_done   = proc_row == ROW_W'(MAX_ROWS - 1);

  // Sweep window. col_cnt is the column entering the window; the cell being
  // decided is the one before it. Columns past the grid in use enter as dead,
  // and cells past it keep their old value.
  assign col_raw   = {next_row[0], cur_row[0], prev_row[0]};
  assign col_live  = DIM_W'(col_cnt) < cols_use;
  assign cell_live = DIM_W'(col_cnt) <= cols_use;

  always_comb begin
    win.left  = win_left;
    win.mid   = win_mid;
    win.right = col_live ? col_raw : 3'b000;
  end

  life_rule_unit u_rule (
    .win        (win),
    .next_alive (rule_bit)
  );

  assign new_bit = cell_live ? rule_bit : win_mid[1];

  life_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd_t'(command))
            CMD_WRITE, CMD_READ: state_next = addr_in_grid ? ST_ACCESS : ST_RESP;
            CMD_STEP:            state_next = grid_empty ? ST_RESP : ST_FETCH;
            default:             state_next = ST_RESP;
          endcase
        end
      end
      ST_ACCESS: state_next = ST_RESP;
      ST_FETCH:  state_next = ST_LOAD;
      ST_LOAD:   state_next = (fetch_row == '0) ? ST_FETCH : ST_SWEEP;
      ST_SWEEP: begin
        if (col_cnt == CCNT_W'(MAX_COLS)) state_next = ST_WRITE;
      end
      ST_WRITE:  state_next = last_row ? ST_RESP : ST_LOAD;
      ST_RESP: begin
        if (resp_load) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory control. The write of a finished row shares its cycle with the
  // read of the row two below it.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_row;
    ram_wdata = new_row;
    ram_raddr = fetch_row[ROW_W-1:0];
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = row;
      end
      ST_ACCESS: begin
        ram_we           = (cmd_q == CMD_WRITE);
        ram_waddr        = row_q;
        ram_wdata        = ram_rdata;
        ram_wdata[col_q] = value_q;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      out_valid   <= 1'b0;
      grid_width  <= GRID_DIM_RESET;
      grid_height <= GRID_DIM_RESET;
      proc_row    <= '0;
      fetch_row   <= '0;
      col_cnt     <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end

      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          proc_row <= clear_done ? '0 : proc_row + ROW_W'(1);
        end
        ST_IDLE: begin
          proc_row  <= '0;
          fetch_row <= '0;
        end
        ST_LOAD: begin
          fetch_row <= fetch_row + RCNT_W'(1);
          col_cnt   <= '0;
        end
        ST_SWEEP: begin
          col_cnt <= col_cnt + CCNT_W'(1);
        end
        ST_WRITE: begin
          if (!last_row) proc_row <= proc_row + ROW_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_q      <= cmd_t'(command);
          col_q      <= col;
          row_q      <= row;
          value_q    <= cell_value;
          result_bit <= 1'b0;
          next_row   <= '0;
        end
      end
      ST_ACCESS: begin
        if (cmd_q == CMD_READ) result_bit <= ram_rdata[col_q];
      end
      ST_LOAD: begin
        // Rows move up by one; a row past the grid in use enters as dead.
        prev_row <= cur_row;
        cur_row  <= next_row;
        next_row <= fetch_live ? ram_rdata : '0;
        win_left <= '0;
        win_mid  <= '0;
      end
      ST_SWEEP: begin
        if (col_cnt != '0) new_row <= {new_bit, new_row[MAX_COLS-1:1]};
        win_left <= win_mid;
        win_mid  <= col_raw;
        // A full rotation brings the old rows back into place for the next row.
        if (col_cnt < CCNT_W'(MAX_COLS)) begin
          prev_row <= {prev_row[0], prev_row[MAX_COLS-1:1]};
          cur_row  <= {cur_row[0], cur_row[MAX_COLS-1:1]};
          next_row <= {next_row[0], next_row[MAX_COLS-1:1]};
        end
      end
      ST_RESP: begin
        if (resp_load) cell_state <= result_bit;
      end
      default: ;
    endcase
  end

  // The column counter never runs past one step beyond the last column.
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (col_cnt <= CCNT_W'(MAX_COLS)))
    else $error("sweep column counter out of range");

  // The store is written only by the clearing pass, a host write or a row
  // write-back.
  a_store_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_ACCESS || state == ST_WRITE))
    else $error("cell store written outside a writing state");

  // A new result only ever comes out of the result state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_RESP))
    else $error("result appeared without a finished command");

  // No result is shown while the store is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out_valid)
    else $error("result shown during clearing pass");

endmodule

`default_nettype wire

>>> bench/life_grid_shadow_pkg.sv
// ----------------------------------------------------------------------------
// life_grid_shadow_pkg: shadow grid and result checker for the life grid bench
// Keeps a bit-level copy of the cell store and grid size, works out the
// cell_state of every accepted command, and checks the block's result words
// against those values in order.
// ----------------------------------------------------------------------------
`default_nettype none

package life_grid_shadow_pkg;

  import life_pkg::*;

  class grid_shadow;

    bit               alive      [MAX_ROWS][MAX_COLS];
    bit               next_alive [MAX_ROWS][MAX_COLS];
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
    bit               expected_states [$];
    int               mismatches;

    function new();
      grid_width  = GRID_DIM_RESET;
      grid_height = GRID_DIM_RESET;
      mismatches  = 0;
    endfunction

    // Sizes beyond the store are clamped to it.
    function int cols_in_use();
      return (grid_width > MAX_COLS) ? MAX_COLS : int'(grid_width);
    endfunction

    function int rows_in_use();
      return (grid_height > MAX_ROWS) ? MAX_ROWS : int'(grid_height);
    endfunction

    function int pending();
      return expected_states.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_GRID_WIDTH:  grid_width  = data;
        REG_GRID_HEIGHT: grid_height = data;
        default: ;
      endcase
    endfunction

    // One B3/S23 generation over the grid in use. Cells outside it neither
    // change nor count as neighbors.
    function void step_generation();
      int rows;
      int cols;
      int r;
      int c;
      int dr;
      int dc;
      int nr;
      int nc;
      int count;
      rows = rows_in_use();
      cols = cols_in_use();
      if (rows == 0 || cols == 0) return;
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) begin
          count = 0;
          for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if ((dr != 0 || dc != 0) && nr >= 0 && nr < rows && nc >= 0 && nc < cols)
                count += alive[nr][nc];
            end
          end
          if (alive[r][c])
            next_alive[r][c] = (count >= SURVIVE_LOW && count <= SURVIVE_HIGH);
          else
            next_alive[r][c] = (count == BIRTH_COUNT);
        end
      end
      for (r = 0; r < rows; r++)
        for (c = 0; c < cols; c++)
          alive[r][c] = next_alive[r][c];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] c,
                               logic [ROW_W-1:0] r, logic v);
      bit in_grid;
      bit state;
      in_grid = (r < rows_in_use()) && (c < cols_in_use());
      state   = 1'b0;
      case (cmd)
        CMD_WRITE: if (in_grid) alive[r][c] = v;
        CMD_READ:  if (in_grid) state = alive[r][c];
        CMD_STEP:  step_generation();
        default: ;
      endcase
      expected_states.push_back(state);
    endfunction

    function void check_cell_state(logic actual);
      bit wanted;
      if (expected_states.size() == 0) begin
        $error("cell_state: result word with nothing expected, actual %0b", actual);
        mismatches++;
        return;
      end
      wanted = expected_states.pop_front();
      if (actual !== wanted) begin
        $error("cell_state: expected %0b, actual %0b", wanted, actual);
        mismatches++;
      end
    endfunction

  endclass

endpackage

`default_nettype wire

>>> bench/life_grid_generation_step_test.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step_test: self-checking bench for the life grid block
// Drives cell writes, cell reads, generation steps and the unused command
// through the valid/stall input channel, changes the grid size between
// phases, and checks every result word against a shadow grid that applies
// the B3/S23 rule in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step_test;

  timeunit 1ns;
  timeprecision 1ps;

  import life_pkg::*;
  import life_grid_shadow_pkg::*;

  // The command field has one code the block does not use.
  localparam logic [CMD_W-1:0]     CMD_UNUSED      = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 300;
  localparam int MIX_ITEMS     = 7;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     command;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic                 cell_value;
  logic                 out_valid;
  logic                 out_stall;
  logic                 cell_state;

  grid_shadow shadow;

  // Idle rates in percent, and long receiver hold-offs asked for by the
  // stimulus process and served by the receiver process.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int cycle_count = 0;

  life_grid_generation_step u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .col        (col),
    .row        (row),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_state (cell_state)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog. A correct run ends far below this; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one command word and returns in the time step of the edge that
  // took it. Valid stays high on return, so back-to-back words need no
  // second assignment to in_valid in one step. Optional idle cycles come
  // first, with valid low.
  task automatic issue(input logic [CMD_W-1:0] cmd, input int c, input int r,
                       input logic v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    col        <= COL_W'(c);
    row        <= ROW_W'(r);
    cell_value <= v;
    // Outputs are read before this edge's updates land, so in_stall here is
    // the value the block showed for the edge itself.
    do @(posedge clk); while (in_stall);
    shadow.note_command(cmd, COL_W'(c), ROW_W'(r), v);
  endtask

  // Stops offering words and waits until every result word has come back,
  // then lets the block finish its last command before the next setting.
  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    shadow.set_register(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input int width, input int height);
    write_register(REG_GRID_WIDTH, CFG_W'(width));
    write_register(REG_GRID_HEIGHT, CFG_W'(height));
  endtask

  // One random word. Most addresses fall inside the grid in use so that
  // reads see what writes and steps left there; the rest probe the outside,
  // the unused command, and steps.
  task automatic random_command();
    int cols;
    int rows;
    int c;
    int r;
    int pick;
    cols = shadow.cols_in_use();
    rows = shadow.rows_in_use();
    c    = (cols > 0) ? $urandom_range(0, cols - 1) : $urandom_range(0, MAX_COLS - 1);
    r    = (rows > 0) ? $urandom_range(0, rows - 1) : $urandom_range(0, MAX_ROWS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 14)
      issue(CMD_STEP, $urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
            1'($urandom_range(0, 1)));
    else if (pick < 50)
      issue(CMD_READ, c, r, 1'($urandom_range(0, 1)));
    else if (pick < 85)
      issue(CMD_WRITE, c, r, 1'($urandom_range(0, 1)));
    else if (pick < 92)
      issue(CMD_UNUSED, $urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
            1'($urandom_range(0, 1)));
    else
      issue($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, $urandom_range(0, MAX_COLS - 1),
            $urandom_range(0, MAX_ROWS - 1), 1'($urandom_range(0, 1)));
  endtask

  // A random phase at one grid size. A seeded phase first writes every cell
  // of a small grid with random values, so that the steps that follow work
  // on a full pattern rather than on a nearly empty grid.
  task automatic random_phase(input int width, input int height, input bit seeded);
    int r;
    int c;
    int n;
    set_grid(width, height);
    if (seeded)
      for (r = 0; r < shadow.rows_in_use(); r++)
        for (c = 0; c < shadow.cols_in_use(); c++)
          issue(CMD_WRITE, c, r, 1'($urandom_range(0, 1)));
    for (n = 0; n < MIX_ITEMS; n++)
      random_command();
    settle();
  endtask

  // Result side: checks each word taken and draws the next stall. A long
  // hold-off, once asked for, keeps stall high until hold_left runs down, so
  // that the output register fills and the block stalls its input.
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        shadow.check_cell_state(cell_state);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    shadow        = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    command       = CMD_WRITE;
    col           = '0;
    row           = '0;
    cell_value    = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 85;
    hold_requests = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset size of 100 by 100: corners of the grid in use, a write just
    // past the last column that must be dropped, and the unused command with
    // every address bit set.
    issue(CMD_WRITE, 0, 0, 1'b1);
    issue(CMD_READ, 0, 0, 1'b0);
    issue(CMD_WRITE, 99, 99, 1'b1);
    issue(CMD_READ, 99, 99, 1'b0);
    issue(CMD_WRITE, 100, 5, 1'b1);
    issue(CMD_READ, 100, 5, 1'b0);
    issue(CMD_UNUSED, MAX_COLS - 1, MAX_ROWS - 1, 1'b1);
    settle();

    // A width past the store clamps to 128 columns, so the last column is
    // live. A row of three against the right edge turns into a column.
    // The unmapped indexes must change nothing.
    set_grid(255, 3);
    write_register(REG_UNMAPPED_LO, CFG_W'($urandom));
    write_register(REG_UNMAPPED_HI, CFG_W'($urandom));
    issue(CMD_WRITE, 125, 1, 1'b1);
    issue(CMD_WRITE, 126, 1, 1'b1);
    issue(CMD_WRITE, 127, 1, 1'b1);
    issue(CMD_STEP, 0, 0, 1'b0);
    issue(CMD_READ, 126, 0, 1'b0);
    issue(CMD_READ, 127, 1, 1'b0);
    settle();

    // Zero width, then zero height: no cell is in use, so reads give 0,
    // writes are dropped and a step does nothing.
    set_grid(0, 4);
    issue(CMD_WRITE, 0, 0, 1'b1);
    issue(CMD_READ, 0, 0, 1'b0);
    issue(CMD_STEP, 0, 0, 1'b0);
    settle();
    set_grid(5, 0);
    issue(CMD_READ, 0, 0, 1'b0);
    settle();

    // A single-cell grid: a lone live cell has no neighbors and dies.
    set_grid(1, 1);
    issue(CMD_WRITE, 0, 0, 1'b1);
    issue(CMD_STEP, 0, 0, 1'b0);
    issue(CMD_READ, 0, 0, 1'b0);
    settle();

    // Full store, with an oversized height. Cells left outside the smaller
    // grids kept their values and show again; one full-size step follows.
    set_grid(128, 255);
    issue(CMD_READ, 126, 1, 1'b0);
    issue(CMD_READ, 99, 99, 1'b0);
    issue(CMD_STEP, 0, 0, 1'b0);
    issue(CMD_READ, 126, 1, 1'b0);
    settle();

    // Random part, sender idle 20% and receiver 85%. The second phase
    // carries the long receiver hold-off.
    random_phase($urandom_range(3, 5), $urandom_range(2, 4), 1'b1);
    hold_requests++;
    random_phase(255, 2, 1'b0);

    // Sender idle 85%, receiver 20%.
    send_idle_pct = 85;
    recv_idle_pct = 20;
    random_phase($urandom_range(2, 6), $urandom_range(2, 5), 1'b1);
    random_phase($urandom_range(1, 16), $urandom_range(0, 8), 1'b0);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase($urandom_range(3, 5), $urandom_range(3, 5), 1'b1);
    random_phase($urandom_range(0, 20), $urandom_range(1, 10), 1'b0);

    if (shadow.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
